// ----- rtl/llex_pkg.sv -----
// Shared types, codes and character helpers for the Lisp token lexer.
`default_nettype none
package llex_pkg;

  // Token kinds carried on the result stream
  typedef enum logic [3:0] {
    K_LPAREN   = 4'd0,
    K_RPAREN   = 4'd1,
    K_DOT      = 4'd2,
    K_QUOTE    = 4'd3,
    K_INTEGER  = 4'd4,
    K_SYMCHAR  = 4'd5,
    K_SYMEND   = 4'd6,
    K_STRCHAR  = 4'd7,
    K_STREND   = 4'd8,
    K_UNCLOSED = 4'd9,
    K_TOOLONG  = 4'd10
  } kind_e;

  // Lexer modes
  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_INT  = 3'd1,
    M_SYM  = 3'd2,
    M_STR  = 3'd3,
    M_ESC  = 3'd4,
    M_ERR  = 3'd5
  } mode_e;

  localparam logic [7:0] SymLenReset = 8'd30;
  localparam int unsigned PosOutBits = 16;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChLparen  = 8'h28;
  localparam logic [7:0] ChRparen  = 8'h29;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChQuote   = 8'h27;
  localparam logic [7:0] ChDquote  = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChPrintLo = 8'h21;
  localparam logic [7:0] ChPrintHi = 8'h7E;

  // One result item
  typedef struct packed {
    kind_e                 kind;
    logic [31:0]           value;
    logic [PosOutBits-1:0] line;
    logic [PosOutBits-1:0] column;
    logic                  last;
  } tok_t;

  // Byte continues a symbol; a symbol starts only with such a byte that is no digit, quote or double quote
  function automatic logic is_sym_char(input logic [7:0] b);
    return (b >= ChPrintLo) && (b <= ChPrintHi) &&
           (b != ChLparen) && (b != ChRparen) && (b != ChDot);
  endfunction

  // Decode the byte after a backslash
  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == 8'h6E) r = 8'd10;
    else if (b == 8'h72) r = 8'd13;
    else if (b == 8'h74) r = 8'd9;
    return r;
  endfunction

  // Build a result item
  function automatic tok_t tok_make(input kind_e k, input logic [31:0] v,
                                    input logic [PosOutBits-1:0] ln,
                                    input logic [PosOutBits-1:0] cl);
    tok_t t;
    t.kind   = k;
    t.value  = v;
    t.line   = ln;
    t.column = cl;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lisp_token_lexer.sv -----
// Top level of the Lisp token lexer: byte decode, lexer state and result queue.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready | tdata: in_byte; tlast: end_of_source
//  m_axis   | out       | m_axis_tvalid/tready | tdata: value,line,column; tuser: kind
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_data: max_symbol_length
//
// One byte is taken per cycle while two queue entries are free; its results (zero, one
// or two) are written to a four-entry result queue in the same cycle and leave one per
// cycle while m_axis_tready is high. The queue drain of one result per cycle sets the
// rate when bytes give two results. Input is held off while more than two entries are occupied.
// Reset clears the lexer state, the queue and sets max_symbol_length to 30.
`default_nettype none
module lisp_token_lexer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // source bytes
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // end_of_source
  // tokens
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] token_value, [47:32] token_line,
                                             // [63:48] token_column
  output logic [3:0]       m_axis_tuser_o,   // [3:0] token_kind
  output logic             m_axis_tlast_o,   // last_of_run
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i        // max_symbol_length
);
  import llex_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

  // State registers
  logic [7:0]               max_len_q;
  mode_e                    mode_q, mode_d, mode_mid;
  logic [31:0]              acc_q, acc_d, acc_mid;
  logic [7:0]               cnt_q, cnt_d, cnt_mid;
  logic [POSITION_BITS-1:0] line_q, line_d, line_mid;
  logic [POSITION_BITS-1:0] col_q, col_d, col_mid;

  // Result queue
  tok_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] q_cnt_q;

  logic       in_xfer, out_xfer;
  logic [7:0] b;
  logic       eos;
  tok_t       res0, res1;
  logic [1:0] res_n;

  assign b        = s_axis_tdata_i;
  assign eos      = s_axis_tlast_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Byte classes
  logic is_nl, is_digit, is_sym, is_dq, is_bs, is_punct;
  logic [31:0] digit_v;
  assign is_nl    = (b == ChNewline);
  assign is_digit = (b >= ChZero) && (b <= ChNine);
  assign is_sym   = is_sym_char(b);
  assign is_dq    = (b == ChDquote);
  assign is_bs    = (b == ChBslash);
  assign is_punct = (b == ChLparen) || (b == ChRparen) || (b == ChDot) ||
                    (b == ChQuote);
  assign digit_v  = 32'(b - ChZero);

  // Saturating counters
  logic [POSITION_BITS-1:0] col_inc, line_inc;
  assign col_inc  = (col_q == PosMax) ? col_q : col_q + PosOne;
  assign line_inc = (line_q == PosMax) ? line_q : line_q + PosOne;

  // Terminated integer or symbol falls through to idle handling
  logic term_int, term_sym, do_idle;
  assign term_int = (mode_q == M_INT) && !is_digit;
  assign term_sym = (mode_q == M_SYM) && !is_sym;
  assign do_idle  = term_int || term_sym ||
                    !((mode_q == M_INT) || (mode_q == M_SYM) || (mode_q == M_STR) ||
                      (mode_q == M_ESC) || (mode_q == M_ERR));

  logic [15:0] line_o, col_o, line_mo, col_mo;
  assign line_o  = 16'(line_q);
  assign col_o   = 16'(col_inc);
  assign line_mo = 16'(line_mid);
  assign col_mo  = 16'(col_mid);

  // Next state
  always_comb begin
    mode_mid = mode_q;
    acc_mid  = acc_q;
    cnt_mid  = cnt_q;
    line_mid = line_q;
    col_mid  = col_q;
    unique case (mode_q)
      M_INT: begin
        if (is_digit) begin
          col_mid = col_inc;
          acc_mid = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + digit_v;
        end
      end
      M_SYM: begin
        if (is_sym) begin
          col_mid = col_inc;
          if (cnt_q >= max_len_q) mode_mid = M_ERR;
          else cnt_mid = cnt_q + 8'd1;
        end
      end
      M_STR: begin
        if (is_nl) begin
          mode_mid = M_ERR;
        end else begin
          col_mid = col_inc;
          if (is_dq) mode_mid = M_IDLE;
          else if (is_bs) mode_mid = M_ESC;
        end
      end
      M_ESC: begin
        col_mid  = col_inc;
        mode_mid = M_STR;
      end
      M_ERR: ;
      default: ;
    endcase
    if (do_idle) begin
      mode_mid = M_IDLE;
      if (is_nl) begin
        line_mid = line_inc;
        col_mid  = PosOne;
      end else begin
        col_mid = col_inc;
        if (is_dq) begin
          mode_mid = M_STR;
        end else if (is_digit) begin
          acc_mid  = digit_v;
          mode_mid = M_INT;
        end else if (is_sym && !is_punct) begin
          if (max_len_q == 8'd0) begin
            mode_mid = M_ERR;
          end else begin
            cnt_mid  = 8'd1;
            mode_mid = M_SYM;
          end
        end
      end
    end
    // Last byte returns the lexer to its reset state
    if (eos) begin
      mode_d = M_IDLE;
      acc_d  = '0;
      cnt_d  = '0;
      line_d = PosOne;
      col_d  = PosOne;
    end else begin
      mode_d = mode_mid;
      acc_d  = acc_mid;
      cnt_d  = cnt_mid;
      line_d = line_mid;
      col_d  = col_mid;
    end
  end

  // Results for this byte
  always_comb begin
    tok_t t;
    logic has;
    res0  = tok_make(K_LPAREN, '0, '0, '0);
    res1  = res0;
    res_n = 2'd0;
    // token ended by this byte
    has = 1'b0;
    t   = res0;
    if (term_int) begin
      t = tok_make(K_INTEGER, acc_q, line_o, 16'(col_q)); has = 1'b1;
    end else if (term_sym) begin
      t = tok_make(K_SYMEND, '0, line_o, 16'(col_q)); has = 1'b1;
    end
    if (has) begin
      res0 = t; res_n = 2'd1;
    end
    // token from the byte itself
    has = 1'b0;
    unique case (mode_q)
      M_SYM: begin
        if (is_sym) begin
          has = 1'b1;
          if (cnt_q >= max_len_q) t = tok_make(K_TOOLONG, '0, line_o, col_o);
          else t = tok_make(K_SYMCHAR, 32'(b), line_o, col_o);
        end
      end
      M_STR: begin
        has = !is_bs;
        if (is_nl) t = tok_make(K_UNCLOSED, '0, line_o, 16'(col_q));
        else if (is_dq) t = tok_make(K_STREND, '0, line_o, col_o);
        else t = tok_make(K_STRCHAR, 32'(b), line_o, col_o);
      end
      M_ESC: begin
        has = 1'b1;
        t   = tok_make(K_STRCHAR, 32'(unescape(b)), line_o, col_o);
      end
      default: ;
    endcase
    if (do_idle) begin
      has = 1'b1;
      if (b == ChLparen) t = tok_make(K_LPAREN, '0, line_o, col_o);
      else if (b == ChRparen) t = tok_make(K_RPAREN, '0, line_o, col_o);
      else if (b == ChDot) t = tok_make(K_DOT, '0, line_o, col_o);
      else if (b == ChQuote) t = tok_make(K_QUOTE, '0, line_o, col_o);
      else if (is_sym && !is_dq && !is_digit) begin
        if (max_len_q == 8'd0) t = tok_make(K_TOOLONG, '0, line_o, col_o);
        else t = tok_make(K_SYMCHAR, 32'(b), line_o, col_o);
      end else has = 1'b0;
    end
    if (has) begin
      if (res_n == 2'd0) res0 = t;
      else res1 = t;
      res_n = res_n + 2'd1;
    end
    // close what the last byte leaves open
    if (eos) begin
      has = 1'b0;
      if (mode_mid == M_INT) begin
        t = tok_make(K_INTEGER, acc_mid, line_mo, col_mo); has = 1'b1;
      end else if (mode_mid == M_SYM) begin
        if (res_n == 2'd2) res1.kind = K_SYMEND;
        else begin
          t = tok_make(K_SYMEND, '0, line_mo, col_mo); has = 1'b1;
        end
      end else if ((mode_mid == M_STR) || (mode_mid == M_ESC)) begin
        t = tok_make(K_UNCLOSED, '0, line_mo, col_mo); has = 1'b1;
      end
      if (has && (res_n != 2'd2)) begin
        if (res_n == 2'd0) res0 = t;
        else res1 = t;
        res_n = res_n + 2'd1;
      end
    end
    // mark the final result of this byte
    if (res_n == 2'd1) res0.last = 1'b1;
    if (res_n == 2'd2) res1.last = 1'b1;
  end

  // Lexer state and configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= SymLenReset;
      mode_q    <= M_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      line_q    <= PosOne;
      col_q     <= PosOne;
    end else begin
      if (cfg_valid_i) max_len_q <= cfg_data_i;
      if (in_xfer) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
        line_q <= line_d;
        col_q  <= col_d;
      end
    end
  end

  // Result queue storage
  logic [1:0] push_n;
  assign push_n = in_xfer ? res_n : 2'd0;
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem[wr_ptr_q] <= res0;
    if (push_n == 2'd2) q_mem[wr_ptr_q + QPtrW'(1)] <= res1;
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (out_xfer) rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      q_cnt_q <= q_cnt_q + QCntW'(push_n) - QCntW'(out_xfer);
    end
  end

  // Hold off input unless two entries are free
  assign s_axis_tready_o = (q_cnt_q <= QCntW'(QDepth - 2));

  // Present the queue head
  tok_t head;
  assign head            = q_mem[rd_ptr_q];
  assign m_axis_tvalid_o = (q_cnt_q != '0);
  assign m_axis_tdata_o  = {head.column, head.line, head.value};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

`ifndef ASSERT_OFF
  a_q_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_eos_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tlast_i |=> mode_q == M_IDLE && line_q == PosOne && col_q == PosOne)
    else $error("lexer state not cleared after last byte");

  a_pos_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0 && col_q != '0)
    else $error("line or column counter reached zero");

  a_kind_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= K_TOOLONG)
    else $error("result kind out of range");
`endif

endmodule
`default_nettype wire

// ----- dv/lisp_token_lexer_test.sv -----
// Testbench for lisp_token_lexer: byte stream in, predicted token stream checked.
`timescale 1ns / 100ps

module lisp_token_lexer_test;
  import llex_pkg::*;

  localparam int unsigned PosBits    = 16;
  localparam int unsigned CycleLimit = 3000000;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChAllHi = 8'hFF;
  localparam logic [7:0] ChEscN  = 8'h6E;
  localparam logic [7:0] ChEscR  = 8'h72;
  localparam logic [7:0] ChEscT  = 8'h74;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowC  = 8'h63;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChOne   = 8'h31;

  typedef struct {
    logic [7:0] data;
    logic       eos;
  } src_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        src_valid  = 1'b0;
  logic [7:0]  src_data   = '0;
  logic        src_last   = 1'b0;
  logic        sink_ready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [7:0]  cfg_data   = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_ready_o;

  // Stimulus and expectation stores
  src_item_t   source_q[$];
  logic [7:0]  src_buf[$];
  tok_t        token_q[$];

  // Lexer prediction state
  mode_e              cur_mode;
  logic [31:0]        acc;
  logic [7:0]         sym_cnt;
  logic [PosBits-1:0] line_no;
  logic [PosBits-1:0] col_no;
  logic [7:0]         sym_limit;
  tok_t               run_tok[2];
  int                 run_n;

  // Run control
  bit          failed;
  int unsigned cycles;
  int unsigned bytes_taken;
  int          src_gap_odds;
  int          sink_stall_odds;
  int          gap_left;
  int          stall_left;
  int          hold_left;
  bit          hold_done;

  lisp_token_lexer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (src_data),
    .s_axis_tlast_i  (src_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (sink_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------
  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= ChZero && ch <= ChNine;
  endfunction

  function automatic logic sym_byte(input logic [7:0] ch);
    return ch >= ChPrintLo && ch <= ChPrintHi &&
           ch != ChLparen && ch != ChRparen && ch != ChDot;
  endfunction

  function automatic void clear_lexer();
    cur_mode = M_IDLE;
    acc      = '0;
    sym_cnt  = '0;
    line_no  = 1;
    col_no   = 1;
  endfunction

  function automatic void step_col();
    if (col_no != '1) col_no++;
  endfunction

  // Append a token at the current position; a byte yields two at most
  function automatic void add_tok(input kind_e k, input logic [31:0] v);
    if (run_n < 2) begin
      run_tok[run_n].kind   = k;
      run_tok[run_n].value  = v;
      run_tok[run_n].line   = line_no[15:0];
      run_tok[run_n].column = col_no[15:0];
      run_tok[run_n].last   = 1'b0;
      run_n++;
    end
  endfunction

  // Handle a byte seen between tokens
  function automatic void start_token(input logic [7:0] ch);
    if (ch == ChNewline) begin
      if (line_no != '1) line_no++;
      col_no = 1;
    end else begin
      step_col();
      if (ch == ChLparen) add_tok(K_LPAREN, '0);
      else if (ch == ChRparen) add_tok(K_RPAREN, '0);
      else if (ch == ChDot) add_tok(K_DOT, '0);
      else if (ch == ChQuote) add_tok(K_QUOTE, '0);
      else if (ch == ChDquote) cur_mode = M_STR;
      else if (is_digit(ch)) begin
        acc      = {24'd0, ch - ChZero};
        cur_mode = M_INT;
      end else if (sym_byte(ch)) begin
        if (sym_limit == 0) begin
          add_tok(K_TOOLONG, '0);
          cur_mode = M_ERR;
        end else begin
          sym_cnt  = 1;
          add_tok(K_SYMCHAR, {24'd0, ch});
          cur_mode = M_SYM;
        end
      end
    end
  endfunction

  // Advance the lexer by one accepted byte and queue the tokens it causes
  function automatic void lex_byte(input logic [7:0] ch, input logic eos);
    logic [7:0] dec;
    run_n = 0;
    case (cur_mode)
      M_INT: begin
        if (is_digit(ch)) begin
          step_col();
          acc = acc * 32'd10 + {24'd0, ch - ChZero};
        end else begin
          add_tok(K_INTEGER, acc);
          cur_mode = M_IDLE;
          start_token(ch);
        end
      end
      M_SYM: begin
        if (sym_byte(ch)) begin
          step_col();
          if (sym_cnt >= sym_limit) begin
            add_tok(K_TOOLONG, '0);
            cur_mode = M_ERR;
          end else begin
            sym_cnt++;
            add_tok(K_SYMCHAR, {24'd0, ch});
          end
        end else begin
          add_tok(K_SYMEND, '0);
          cur_mode = M_IDLE;
          start_token(ch);
        end
      end
      M_STR: begin
        if (ch == ChNewline) begin
          add_tok(K_UNCLOSED, '0);
          cur_mode = M_ERR;
        end else begin
          step_col();
          if (ch == ChDquote) begin
            add_tok(K_STREND, '0);
            cur_mode = M_IDLE;
          end else if (ch == ChBslash) begin
            cur_mode = M_ESC;
          end else begin
            add_tok(K_STRCHAR, {24'd0, ch});
          end
        end
      end
      M_ESC: begin
        step_col();
        dec = ch;
        if (ch == ChEscN) dec = ChNewline;
        else if (ch == ChEscR) dec = ChCr;
        else if (ch == ChEscT) dec = ChTab;
        add_tok(K_STRCHAR, {24'd0, dec});
        cur_mode = M_STR;
      end
      M_ERR: ;
      default: begin
        cur_mode = M_IDLE;
        start_token(ch);
      end
    endcase

    // Close what is open at the end of the source, then start over
    if (eos) begin
      if (cur_mode == M_INT) begin
        add_tok(K_INTEGER, acc);
      end else if (cur_mode == M_SYM) begin
        // integer then a one-character symbol: the symbol char becomes its end
        if (run_n == 2) run_tok[1].kind = K_SYMEND;
        else add_tok(K_SYMEND, '0);
      end else if (cur_mode == M_STR || cur_mode == M_ESC) begin
        add_tok(K_UNCLOSED, '0);
      end
      clear_lexer();
    end

    if (run_n > 0) run_tok[run_n-1].last = 1'b1;
    for (int i = 0; i < run_n; i++) token_q.push_back(run_tok[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Source driver: one byte transfer per handshake, random gap bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    src_item_t nxt;
    if (rst_ni) begin
      if (src_valid && s_axis_tready_o) begin
        lex_byte(src_data, src_last);
        bytes_taken++;
      end
      if (!src_valid || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          src_valid <= 1'b0;
        end else if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
          gap_left  = $urandom_range(0, 16);
          src_valid <= 1'b0;
        end else if (source_q.size() != 0) begin
          nxt       = source_q.pop_front();
          src_valid <= 1'b1;
          src_data  <= nxt.data;
          src_last  <= nxt.eos;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Token sink ready: random stall bursts plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        sink_ready <= 1'b0;
      end else if (!hold_done && bytes_taken >= 320) begin
        hold_done = 1'b1;
        hold_left = 400;
        sink_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
        stall_left = $urandom_range(0, 16);
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Token monitor: compare each transfer with the oldest expectation
  always @(posedge clk_i) begin
    tok_t want;
    if (rst_ni && m_axis_tvalid_o && sink_ready) begin
      if (token_q.size() == 0) begin
        $error("token_kind %0d arrived with no token expected", m_axis_tuser_o);
        failed = 1'b1;
      end else begin
        want = token_q.pop_front();
        if (m_axis_tuser_o !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser_o);
          failed = 1'b1;
        end
        if (m_axis_tdata_o[31:0] !== want.value) begin
          $error("token_value: expected %0d, got %0d",
                 $signed(want.value), $signed(m_axis_tdata_o[31:0]));
          failed = 1'b1;
        end
        if (m_axis_tdata_o[47:32] !== want.line) begin
          $error("token_line: expected %0d, got %0d", want.line, m_axis_tdata_o[47:32]);
          failed = 1'b1;
        end
        if (m_axis_tdata_o[63:48] !== want.column) begin
          $error("token_column: expected %0d, got %0d", want.column, m_axis_tdata_o[63:48]);
          failed = 1'b1;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** lisp_token_lexer: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send(input logic [7:0] ch, input logic eos = 1'b0);
    src_item_t it;
    it.data = ch;
    it.eos  = eos;
    source_q.push_back(it);
  endtask

  // Wait until every byte is taken and every token has arrived
  task automatic drain();
    while (source_q.size() != 0 || src_valid || token_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_sym_limit(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sym_limit = v;
  endtask

  function automatic logic [7:0] sym_start();
    logic [7:0] ch;
    do ch = 8'($urandom_range(ChPrintLo, ChPrintHi));
    while (!sym_byte(ch) || is_digit(ch) || ch == ChDquote || ch == ChQuote);
    return ch;
  endfunction

  function automatic logic [7:0] sym_any();
    logic [7:0] ch;
    do ch = 8'($urandom_range(ChPrintLo, ChPrintHi)); while (!sym_byte(ch));
    return ch;
  endfunction

  // Plain string content: mostly printable, sometimes control or high bytes
  function automatic logic [7:0] str_plain();
    logic [7:0] ch;
    if ($urandom_range(0, 11) == 0) begin
      do ch = 8'($urandom_range(0, 255));
      while (ch == ChNewline || ch == ChDquote || ch == ChBslash);
    end else begin
      do ch = 8'($urandom_range(ChSpace, ChTilde)); while (ch == ChDquote || ch == ChBslash);
    end
    return ch;
  endfunction

  // Add one random token, or noise, and mostly a separator to the source buffer
  task automatic add_construct();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      case ($urandom_range(0, 3))
        0: src_buf.push_back(ChLparen);
        1: src_buf.push_back(ChRparen);
        2: src_buf.push_back(ChDot);
        default: src_buf.push_back(ChQuote);
      endcase
    end else if (pick < 32) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
      repeat (len) src_buf.push_back(ChZero + 8'($urandom_range(0, 9)));
    end else if (pick < 58) begin
      if (sym_limit <= 40 && $urandom_range(0, 5) == 0)
        len = sym_limit + $urandom_range(0, 1);
      else
        len = $urandom_range(1, (sym_limit < 8) ? sym_limit + 1 : 8);
      src_buf.push_back(sym_start());
      repeat (len - 1) src_buf.push_back(sym_any());
    end else if (pick < 80) begin
      src_buf.push_back(ChDquote);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 5) == 0) begin
          src_buf.push_back(ChBslash);
          case ($urandom_range(0, 3))
            0: src_buf.push_back(ChEscN);
            1: src_buf.push_back(ChEscR);
            2: src_buf.push_back(ChEscT);
            default: src_buf.push_back(8'($urandom_range(0, 255)));
          endcase
        end else begin
          src_buf.push_back(str_plain());
        end
      end
      // mostly closed; sometimes broken by a raw newline or left open
      case ($urandom_range(0, 19))
        0: src_buf.push_back(ChNewline);
        1: ;
        default: src_buf.push_back(ChDquote);
      endcase
    end else begin
      src_buf.push_back(8'($urandom_range(0, 255)));
    end

    pick = $urandom_range(0, 9);
    if (pick < 6) src_buf.push_back(ChSpace);
    else if (pick == 6) src_buf.push_back(ChNewline);
    else if (pick == 7) src_buf.push_back(ChTab);
  endtask

  // Queue random source texts, each closed by its last byte
  task automatic queue_sources(input int total);
    int made;
    int target;
    made = 0;
    while (made < total) begin
      src_buf.delete();
      target = $urandom_range(4, 40);
      while (src_buf.size() < target) add_construct();
      // drop the trailing byte half the time so the end lands inside a token
      if ($urandom_range(0, 1) == 1) void'(src_buf.pop_back());
      made += src_buf.size();
      foreach (src_buf[i]) send(src_buf[i], i == src_buf.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    clear_lexer();
    sym_limit       = SymLenReset;
    src_gap_odds    = 3;
    sink_stall_odds = 3;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Punctuation, integer into symbol, skipped bytes, escapes, string end
    send(ChLparen); send(ChRparen); send(ChDot); send(ChQuote);
    send(ChZero); send(ChNine); send(ChLowX); send(ChNul);
    send(ChNewline); send(ChAllHi);
    send(ChDquote); send(ChBslash); send(ChEscN); send(ChBslash); send(ChEscR);
    send(ChBslash); send(ChEscT); send(ChBslash); send(ChNewline); send(ChDquote);
    // integer then a one-character symbol at the end of the source
    send(ChOne); send(ChTilde, 1'b1);
    // end of source inside an escape
    send(ChDquote); send(ChBslash, 1'b1);
    // raw newline in a string, then discard up to the last byte
    send(ChDquote); send(ChLowA); send(ChNewline); send(ChLowB); send(ChRparen, 1'b1);
    drain();

    // Symbol limit of one: second character is too long
    set_sym_limit(8'd1);
    send(ChLowA); send(ChLowB); send(ChLowC, 1'b1);
    src_gap_odds    = 0;
    sink_stall_odds = 5;
    queue_sources(100);
    drain();

    // Longest symbol limit, with one symbol running past it
    set_sym_limit(8'd255);
    src_gap_odds    = 6;
    sink_stall_odds = 0;
    send(sym_start());
    repeat (255) send(sym_any());
    send(ChSpace, 1'b1);
    queue_sources(60);
    drain();

    set_sym_limit(SymLenReset);
    src_gap_odds    = 4;
    sink_stall_odds = 4;
    queue_sources(90);
    drain();

    set_sym_limit(8'($urandom_range(2, 10)));
    src_gap_odds    = 10;
    sink_stall_odds = 2;
    queue_sources(90);
    drain();

    // Last part: no idling on either side
    set_sym_limit(8'($urandom_range(1, 255)));
    src_gap_odds    = 0;
    sink_stall_odds = 0;
    while (gap_left != 0 || stall_left != 0) @(posedge clk_i);
    queue_sources(90);
    drain();

    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("** lisp_token_lexer: PASSED **");
    end else begin
      $display("** lisp_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule
